@@ rtl/counting_bloom_filter_update_core_defines.svh @@
// Assertion helpers shared by the RTL; all sample on i_clk, off during reset.
`ifndef COUNTING_BLOOM_FILTER_UPDATE_CORE_DEFINES_SVH
`define COUNTING_BLOOM_FILTER_UPDATE_CORE_DEFINES_SVH

// condition holds on every clock
`define CBF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cbf_pkg.sv @@
package cbf_pkg;

    localparam int KEY_W  = 256;
    localparam int WORD_W = 64;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 5;
    localparam int CTR_W  = 8;

    localparam logic [CTR_W-1:0] CTR_MAX = 8'hFF;
    localparam logic [CTR_W-1:0] CTR_ONE = 8'h01;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic REG_NUM_HASHES = 1'b0;
    localparam logic REG_INDEX_BITS = 1'b1;

    localparam logic [CFG_W-1:0] NUM_HASHES_RST = 5'd10;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST = 5'd4;

    typedef struct packed {
        logic load;
        logic shift;
    } t_slice_ctl;

endpackage

@@ rtl/cbf_ram.sv @@
module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cbf_slicer.sv @@
module cbf_slicer
    import cbf_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 16
) (
    input  logic                                  i_clk,
    input  t_slice_ctl                            i_ctl,
    input  logic [KEY_W-1:0]                      i_key,
    input  logic [$clog2(MAX_INDEX_BITS+1)-1:0]   i_width,
    output logic [MAX_INDEX_BITS-1:0]             o_idx
);

    localparam int IW = $clog2(MAX_INDEX_BITS + 1);

    logic [KEY_W-1:0] r_key;
    logic [IW-1:0]    shamt;

    // stream bit 0 sits at the MSB; each slice is taken from the top
    assign shamt = IW'(MAX_INDEX_BITS) - i_width;
    assign o_idx = r_key[KEY_W-1 -: MAX_INDEX_BITS] >> shamt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= i_key;
        end else if (i_ctl.shift) begin
            r_key <= r_key << i_width;
        end
    end

endmodule

@@ rtl/cbf_ctr_alu.sv @@
module cbf_ctr_alu
    import cbf_pkg::*;
(
    input  logic             i_is_add,
    input  logic [CTR_W-1:0] i_old,
    output logic [CTR_W-1:0] o_new,
    output logic             o_hit
);

    always_comb begin
        if (i_is_add) begin
            o_hit = (i_old == CTR_MAX);
            o_new = o_hit ? i_old : i_old + CTR_ONE;
        end else begin
            o_hit = (i_old == CTR_ONE);
            o_new = (i_old == '0) ? i_old : i_old - CTR_ONE;
        end
    end

endmodule

@@ rtl/counting_bloom_filter_update_core.sv @@
// Counting Bloom filter update core. Each input word carries a 256-bit key in
// tdata (key_word_0 in the low bits, its bit 63 first in the stream) and the
// operation in tuser. Add or remove works through the index slices one by one:
// each slice is a read then a write on the single counter RAM. Clear sweeps
// the RAM one counter per cycle. After reset the same sweep runs before the
// first word is taken; configuration writes are taken throughout. One result
// word is produced per input word and the next input word is taken while a
// result still waits.
`include "counting_bloom_filter_update_core_defines.svh"

module counting_bloom_filter_update_core
    import cbf_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 16,
    parameter int KEY_BITS       = 256,
    parameter int MAX_HASHES     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [KEY_W-1:0]  s_axis_tdata,  // key_word_0, key_word_1, key_word_2, key_word_3
    input  logic [KIND_W-1:0] s_axis_tuser,  // kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata   // flag, zero pad
);

    localparam int AW = MAX_INDEX_BITS;
    localparam int IW = $clog2(MAX_INDEX_BITS + 1);
    localparam int HW = $clog2(MAX_HASHES + 1);
    localparam int PW = $clog2(KEY_BITS + 1);
    localparam int SW = $clog2(KEY_BITS + MAX_INDEX_BITS + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_clr_cmd, n_clr_cmd;
    logic             r_is_add, n_is_add;
    logic [HW-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]    r_pos, n_pos;
    logic [IW-1:0]    r_width, n_width;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_flag, n_flag;
    logic             r_out_valid, n_out_valid;
    logic             r_out_flag, n_out_flag;
    logic [CFG_W-1:0] r_num_hashes, r_index_bits;

    logic             accept;
    logic [SW-1:0]    pos_sum;
    logic             slice_go;
    t_slice_ctl       slice_ctl;
    logic [AW-1:0]    slice_idx;
    logic [KEY_W-1:0] key_stream;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CTR_W-1:0] ram_wdata;
    logic             ram_re;
    logic [CTR_W-1:0] ram_rdata;
    logic [CTR_W-1:0] alu_new;
    logic             alu_hit;
    logic             wr_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_flag};

    assign key_stream = {s_axis_tdata[WORD_W-1:0], s_axis_tdata[2*WORD_W-1:WORD_W],
                         s_axis_tdata[3*WORD_W-1:2*WORD_W], s_axis_tdata[4*WORD_W-1:3*WORD_W]};

    assign pos_sum  = SW'(r_pos) + SW'(r_width);
    assign slice_go = (r_state == S_RD) && (r_cnt != '0) && (pos_sum <= SW'(KEY_BITS));

    assign slice_ctl.load  = accept;
    assign slice_ctl.shift = slice_go;

    assign ram_re    = slice_go;
    assign ram_we    = (r_state == S_CLR) || (r_state == S_WR);
    assign ram_waddr = (r_state == S_CLR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == S_CLR) ? '0 : alu_new;

    assign wr_sat = (r_state == S_WR) && r_is_add && (ram_rdata == CTR_MAX);

    cbf_slicer #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_slicer (
        .i_clk   (i_clk),
        .i_ctl   (slice_ctl),
        .i_key   (key_stream),
        .i_width (r_width),
        .o_idx   (slice_idx)
    );

    cbf_ram #(
        .WIDTH (CTR_W),
        .DEPTH (2 ** MAX_INDEX_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (slice_idx),
        .o_rdata (ram_rdata)
    );

    cbf_ctr_alu u_alu (
        .i_is_add (r_is_add),
        .i_old    (ram_rdata),
        .o_new    (alu_new),
        .o_hit    (alu_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_cmd   = r_clr_cmd;
        n_is_add    = r_is_add;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_width     = r_width;
        n_addr      = r_addr;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_flag  = r_out_flag;

        case (r_state)
            S_CLR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_is_add = (s_axis_tuser == KIND_ADD);
                    n_flag   = 1'b0;
                    n_pos    = '0;
                    if (32'(r_num_hashes) > MAX_HASHES) begin
                        n_cnt = HW'(MAX_HASHES);
                    end else begin
                        n_cnt = HW'(r_num_hashes);
                    end
                    if (r_index_bits == '0) begin
                        n_width = IW'(1);
                    end else if (32'(r_index_bits) > MAX_INDEX_BITS) begin
                        n_width = IW'(MAX_INDEX_BITS);
                    end else begin
                        n_width = IW'(r_index_bits);
                    end
                    if (s_axis_tuser inside {KIND_ADD, KIND_REMOVE}) begin
                        n_state = S_RD;
                    end else if (s_axis_tuser == KIND_CLEAR) begin
                        n_state    = S_CLR;
                        n_clr_cmd  = 1'b1;
                        n_clr_addr = '0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                if (slice_go) begin
                    n_addr  = slice_idx;
                    n_pos   = PW'(pos_sum);
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WR: begin
                n_flag  = r_flag || alu_hit;
                n_state = S_RD;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_flag  = r_flag;
                    n_clr_cmd   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_clr_cmd    <= 1'b0;
            r_pos        <= '0;
            r_flag       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_num_hashes <= NUM_HASHES_RST;
            r_index_bits <= INDEX_BITS_RST;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_cmd   <= n_clr_cmd;
            r_pos       <= n_pos;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_NUM_HASHES) begin
                    r_num_hashes <= i_cfg_wdata;
                end else if (i_cfg_index == REG_INDEX_BITS) begin
                    r_index_bits <= i_cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_add   <= n_is_add;
        r_cnt      <= n_cnt;
        r_width    <= n_width;
        r_addr     <= n_addr;
        r_out_flag <= n_out_flag;
    end

    `CBF_ASSERT_NXT(a_accept_leaves_idle, accept, r_state != S_IDLE, "word accepted but idle")
    `CBF_ASSERT_IMP(a_no_write_idle, r_state == S_IDLE || r_state == S_DONE, !ram_we, "stray write")
    `CBF_ASSERT(a_pos_bound, 32'(r_pos) <= KEY_BITS, "slice position past key end")
    `CBF_ASSERT_IMP(a_sat_hold, wr_sat, ram_wdata == CTR_MAX, "saturated counter changed")

endmodule
